FILE: hdl/slcf_pkg.sv
// ----------------------------------------------------------------------------
// slcf_pkg: shared types and constants for the status LED colour frame core
// Mode codes, colour levels, reciprocal constants and the sideband struct
// that travels down the pipeline beside each word.
// ----------------------------------------------------------------------------
package slcf_pkg;

  // Field widths of the stream words
  localparam int ModeW = 4;
  localparam int MsW   = 64;
  localparam int PctW  = 7;
  localparam int ChanW = 8;

  // Mode codes
  localparam logic [ModeW-1:0] MODE_AVAILABLE  = 4'd0;
  localparam logic [ModeW-1:0] MODE_BUSY       = 4'd1;
  localparam logic [ModeW-1:0] MODE_DND        = 4'd2;
  localparam logic [ModeW-1:0] MODE_AUTH       = 4'd3;
  localparam logic [ModeW-1:0] MODE_CFG_ERR    = 4'd4;
  localparam logic [ModeW-1:0] MODE_PLAY       = 4'd5;
  localparam logic [ModeW-1:0] MODE_CONNECTING = 4'd6;
  localparam logic [ModeW-1:0] MODE_UNKNOWN    = 4'd7;
  localparam logic [ModeW-1:0] MODE_LAST       = 4'd8;

  localparam logic [PctW-1:0] MaxPct = 7'd100;

  // Colour levels
  localparam logic [ChanW-1:0] ColFull  = 8'd255;
  localparam logic [ChanW-1:0] ColAvail = 8'd140;
  localparam logic [ChanW-1:0] ColRed   = 8'd180;
  localparam logic [ChanW-1:0] ColIdle  = 8'd140;

  // time_ms mod 27000 covers both the 1500 ms blink cycle and the
  // 5400 ms hue cycle. Reduce (time_ms >> 3) mod 3375 in 12-bit chunks.
  localparam int unsigned TimeMod   = 3375;
  localparam int          ChunkW    = 12;
  localparam int          NumChunks = 6;
  localparam int          ResW      = 15;

  // Reciprocal multipliers: floor(x / d) = (x * recip) >> shift over the range used
  localparam int              ModShift    = 38;
  localparam logic [26:0]     ModRecip    = 27'((64'd1 << ModShift) / TimeMod);
  localparam int              Div15Shift  = 19;
  localparam logic [15:0]     Div15Recip  = 16'(((1 << Div15Shift) + 14) / 15);
  localparam int              Div750Shift = 25;
  localparam logic [15:0]     Div750Recip = 16'(((1 << Div750Shift) + 749) / 750);
  localparam int              PlayShift   = 13;
  localparam logic [11:0]     PlayMul     = 12'(3 * (((1 << PlayShift) + 9) / 10));
  localparam int              Div100Shift = 22;
  localparam logic [15:0]     Div100Recip = 16'(((1 << Div100Shift) + 99) / 100);

  // Hue wheel
  localparam logic [10:0] HueStep = 11'd120;
  localparam logic [10:0] Wheel   = 11'd360;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [PctW-1:0]  pct;
    logic             ok;
    logic             blank;
  } side_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  // Weight of chunk idx: 2^(ChunkW*idx) mod TimeMod, used with constant idx only
  function automatic int unsigned chunk_weight(input int unsigned idx);
    int unsigned r;
    r = 1;
    for (int unsigned k = 0; k < idx; k++) begin
      r = (r * (32'd1 << ChunkW)) % TimeMod;
    end
    return r;
  endfunction

endpackage

FILE: hdl/status_led_color_frame_core.sv
// ----------------------------------------------------------------------------
// status_led_color_frame_core: two status LED colours from mode and time
// Picks the colour of the display mode, runs the play hue wheel and the
// blink phase from the elapsed time, and scales every channel by brightness.
// ----------------------------------------------------------------------------
// Pipeline: nine register stages, the last being the m_axis output register.
// Throughput: one word per cycle; all stages advance together whenever the
//   output register is empty or being taken, and hold otherwise.
// Reset: rst (synchronous, active high) clears every valid bit; data
//   registers keep their contents and are ignored until refilled.
module status_led_color_frame_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // s_axis_tdata, from bit 0: mode[3:0], time_ms[67:4],
  //   bright_pct[74:68], zero fill [79:75]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // m_axis_tdata, from bit 0: ok[0], led0_red[8:1], led0_green[16:9],
  //   led0_blue[24:17], led1_red[32:25], led1_green[40:33],
  //   led1_blue[48:41], zero fill [55:49]
  output logic [55:0] m_axis_tdata
);

  logic [slcf_pkg::ModeW-1:0] mode;
  logic [slcf_pkg::MsW-1:0]   time_ms;
  logic [slcf_pkg::PctW-1:0]  bright_pct;
  logic                       advance;
  slcf_pkg::side_t            in_side;

  logic                       res_valid;
  logic [slcf_pkg::ResW-1:0]  res;
  slcf_pkg::side_t            res_side;

  logic                       hue_valid;
  slcf_pkg::rgb_t             hue;
  slcf_pkg::side_t            hue_side;

  logic                       ok;
  slcf_pkg::rgb_t             led0, led1;

  // Unpack the input word
  assign mode       = s_axis_tdata[3:0];
  assign time_ms    = s_axis_tdata[67:4];
  assign bright_pct = s_axis_tdata[74:68];

  // Advance the whole pipeline while the output register is free or emptying;
  // a stall holds every stage in place.
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;

  // Reject unknown mode codes and brightness above 100 up front; the
  // verdict rides along with the word and zeroes the colour later.
  always_comb begin
    in_side.mode  = mode;
    in_side.pct   = bright_pct;
    in_side.ok    = (mode <= slcf_pkg::MODE_LAST) && (bright_pct <= slcf_pkg::MaxPct);
    in_side.blank = 1'b0;
  end

  // Stages 1-4: time_ms mod 27000
  slcf_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (s_axis_tvalid),
    .in_ms     (time_ms),
    .in_side   (in_side),
    .out_valid (res_valid),
    .out_res   (res),
    .out_side  (res_side)
  );

  // Stages 5-6: blink parity and rainbow hue
  slcf_phase u_phase (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (res_valid),
    .in_res    (res),
    .in_side   (res_side),
    .out_valid (hue_valid),
    .out_hue   (hue),
    .out_side  (hue_side)
  );

  // Stages 7-9: mode colour, brightness, output register
  slcf_color u_color (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (hue_valid),
    .in_hue    (hue),
    .in_side   (hue_side),
    .out_valid (m_axis_tvalid),
    .out_ok    (ok),
    .out_led0  (led0),
    .out_led1  (led1)
  );

  // Pack the result word
  assign m_axis_tdata = {7'd0,
                         led1.blue, led1.green, led1.red,
                         led0.blue, led0.green, led0.red,
                         ok};

endmodule

FILE: hdl/slcf_mod.sv
// ----------------------------------------------------------------------------
// slcf_mod: time residue stages
// Four stages reduce time_ms to time_ms mod 27000.
// ----------------------------------------------------------------------------
module slcf_mod (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [slcf_pkg::MsW-1:0]  in_ms,
  input  slcf_pkg::side_t           in_side,
  output logic                      out_valid,
  output logic [slcf_pkg::ResW-1:0] out_res,
  output slcf_pkg::side_t           out_side
);

  localparam int XW = slcf_pkg::ChunkW * slcf_pkg::NumChunks;

  logic [XW-1:0] xw;
  logic [2*slcf_pkg::ChunkW-1:0] prod_next [slcf_pkg::NumChunks];
  logic [2*slcf_pkg::ChunkW-1:0] prod      [slcf_pkg::NumChunks];
  logic [26:0] sum_next, sum, sum3;
  logic [53:0] qprod;
  logic [15:0] q;
  logic [27:0] rem_wide;
  logic [12:0] rem13;
  logic [11:0] rem12;
  logic [2:0]  low1, low2, low3;
  logic        v1, v2, v3;
  slcf_pkg::side_t side1, side2, side3;

  assign xw = XW'(in_ms[slcf_pkg::MsW-1:3]);

  for (genvar i = 0; i < slcf_pkg::NumChunks; i++) begin : g_chunk
    localparam logic [slcf_pkg::ChunkW-1:0] Weight =
      slcf_pkg::ChunkW'(slcf_pkg::chunk_weight(i));
    assign prod_next[i] = xw[i*slcf_pkg::ChunkW +: slcf_pkg::ChunkW] * Weight;
  end

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < slcf_pkg::NumChunks; i++) begin
      sum_next = sum_next + 27'(prod[i]);
    end
  end

  assign qprod    = 54'(sum) * 54'(slcf_pkg::ModRecip);
  assign rem_wide = 28'(sum3) - 28'(q) * 28'(slcf_pkg::TimeMod);
  assign rem13    = rem_wide[12:0];
  assign rem12    = (rem13 >= 13'(slcf_pkg::TimeMod))
                    ? 12'(rem13 - 13'(slcf_pkg::TimeMod)) : rem13[11:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod     <= prod_next;
      low1     <= in_ms[2:0];
      side1    <= in_side;
      sum      <= sum_next;
      low2     <= low1;
      side2    <= side1;
      q        <= qprod[53:slcf_pkg::ModShift];
      sum3     <= sum;
      low3     <= low2;
      side3    <= side2;
      out_res  <= {rem12, low3};
      out_side <= side3;
    end
  end

endmodule

FILE: hdl/slcf_phase.sv
// ----------------------------------------------------------------------------
// slcf_phase: blink phase and hue wheel
// Two stages: hue degree and blink parity, then the raw rainbow colour.
// ----------------------------------------------------------------------------
module slcf_phase (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [slcf_pkg::ResW-1:0] in_res,
  input  slcf_pkg::side_t           in_side,
  output logic                      out_valid,
  output slcf_pkg::rgb_t            out_hue,
  output slcf_pkg::side_t           out_side
);

  logic [30:0] deg_prod, blink_prod;
  logic [10:0] deg;
  logic        v5;
  slcf_pkg::side_t side5, side5_next;
  logic [10:0] ang;
  logic [6:0]  xr, xg, xb;
  slcf_pkg::rgb_t hue_next;

  assign deg_prod   = 31'(in_res) * 31'(slcf_pkg::Div15Recip);
  assign blink_prod = 31'(in_res) * 31'(slcf_pkg::Div750Recip);

  always_comb begin
    side5_next       = in_side;
    side5_next.blank = blink_prod[slcf_pkg::Div750Shift];
  end

  // Fold the degree count (below 1800) onto the wheel
  always_comb begin
    if (deg >= 11'd1440) begin
      ang = deg - 11'd1440;
    end else if (deg >= 11'd1080) begin
      ang = deg - 11'd1080;
    end else if (deg >= 11'd720) begin
      ang = deg - 11'd720;
    end else if (deg >= slcf_pkg::Wheel) begin
      ang = deg - slcf_pkg::Wheel;
    end else begin
      ang = deg;
    end
  end

  always_comb begin
    xr = '0;
    xg = '0;
    xb = '0;
    if (ang < slcf_pkg::HueStep) begin
      xr = 7'(slcf_pkg::HueStep - ang);
      xg = 7'(ang);
    end else if (ang < 11'd240) begin
      xg = 7'(11'd240 - ang);
      xb = 7'(ang - slcf_pkg::HueStep);
    end else begin
      xr = 7'(ang - 11'd240);
      xb = 7'(slcf_pkg::Wheel - ang);
    end
  end

  // x * 255 / 120 is x * 17 / 8
  always_comb begin
    logic [10:0] pr, pg, pb;
    pr = 11'(xr) * 11'd17;
    pg = 11'(xg) * 11'd17;
    pb = 11'(xb) * 11'd17;
    hue_next.red   = pr[10:3];
    hue_next.green = pg[10:3];
    hue_next.blue  = pb[10:3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v5        <= in_valid;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg      <= deg_prod[29:slcf_pkg::Div15Shift];
      side5    <= side5_next;
      out_hue  <= hue_next;
      out_side <= side5;
    end
  end

endmodule

FILE: hdl/slcf_color.sv
// ----------------------------------------------------------------------------
// slcf_color: colour choice and brightness scaling
// Three stages: mode colour with blanking, brightness product, divide by 100.
// ----------------------------------------------------------------------------
module slcf_color (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  slcf_pkg::rgb_t  in_hue,
  input  slcf_pkg::side_t in_side,
  output logic            out_valid,
  output logic            out_ok,
  output slcf_pkg::rgb_t  out_led0,
  output slcf_pkg::rgb_t  out_led1
);

  logic [19:0] play_r, play_g, play_b;
  slcf_pkg::rgb_t col_next, col;
  slcf_pkg::side_t side7, side8;
  logic        blinks;
  logic        v7, v8;
  logic [14:0] p_red, p_green, p_blue;
  logic [30:0] d_red, d_green, d_blue;
  slcf_pkg::rgb_t led_next;

  // Play colours at 30 %: v * 3 / 10
  assign play_r = 20'(in_hue.red)   * 20'(slcf_pkg::PlayMul);
  assign play_g = 20'(in_hue.green) * 20'(slcf_pkg::PlayMul);
  assign play_b = 20'(in_hue.blue)  * 20'(slcf_pkg::PlayMul);

  assign blinks = (in_side.mode == slcf_pkg::MODE_DND) ||
                  (in_side.mode == slcf_pkg::MODE_AUTH) ||
                  (in_side.mode == slcf_pkg::MODE_CONNECTING) ||
                  (in_side.mode == slcf_pkg::MODE_UNKNOWN);

  always_comb begin
    col_next = '0;
    case (in_side.mode)
      slcf_pkg::MODE_AVAILABLE: begin
        col_next.green = slcf_pkg::ColAvail;
      end
      slcf_pkg::MODE_BUSY, slcf_pkg::MODE_AUTH: begin
        col_next.red   = slcf_pkg::ColFull;
        col_next.green = slcf_pkg::ColFull;
      end
      slcf_pkg::MODE_DND: begin
        col_next.red = slcf_pkg::ColRed;
      end
      slcf_pkg::MODE_CFG_ERR: begin
        col_next.red  = slcf_pkg::ColRed;
        col_next.blue = slcf_pkg::ColRed;
      end
      slcf_pkg::MODE_PLAY: begin
        col_next.red   = 8'(play_r[19:slcf_pkg::PlayShift]);
        col_next.green = 8'(play_g[19:slcf_pkg::PlayShift]);
        col_next.blue  = 8'(play_b[19:slcf_pkg::PlayShift]);
      end
      default: begin
        col_next.blue = slcf_pkg::ColIdle;
      end
    endcase
    // drop the colour for rejected words and dark blink periods
    if (!in_side.ok || (blinks && in_side.blank)) begin
      col_next = '0;
    end
  end

  assign d_red   = 31'(p_red)   * 31'(slcf_pkg::Div100Recip);
  assign d_green = 31'(p_green) * 31'(slcf_pkg::Div100Recip);
  assign d_blue  = 31'(p_blue)  * 31'(slcf_pkg::Div100Recip);

  assign led_next.red   = d_red[29:slcf_pkg::Div100Shift];
  assign led_next.green = d_green[29:slcf_pkg::Div100Shift];
  assign led_next.blue  = d_blue[29:slcf_pkg::Div100Shift];

  always_ff @(posedge clk) begin
    if (rst) begin
      v7        <= 1'b0;
      v8        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v7        <= in_valid;
      v8        <= v7;
      out_valid <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col      <= col_next;
      side7    <= in_side;
      p_red    <= 15'(col.red)   * 15'(side7.pct);
      p_green  <= 15'(col.green) * 15'(side7.pct);
      p_blue   <= 15'(col.blue)  * 15'(side7.pct);
      side8    <= side7;
      out_ok   <= side8.ok;
      out_led0 <= led_next;
      out_led1 <= (side8.mode == slcf_pkg::MODE_BUSY) ? '0 : led_next;
    end
  end

endmodule

FILE: hdl/slcf_checker.sv
// ----------------------------------------------------------------------------
// slcf_checker: port-level checks for the status LED colour frame core
// Watches both stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
module slcf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  // A stalled result word holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // The input side only stalls when the output register is full and blocked
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output backpressure");

  // A rejected word carries no colour
  a_reject_dark: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[55:1] == 55'd0)
    else $error("rejected word has non-zero channels");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result word valid straight after reset");

  // Accepting with a stalled output register would lose a word
  a_no_accept_stalled: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("input word taken while the output is stalled");

endmodule

bind status_led_color_frame_core slcf_checker u_slcf_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for status_led_color_frame_core
// Drives mode / time / brightness words into the stream input, gets every
// LED frame from the directed table or an independent colour predictor,
// compares each output word with the oldest frame still owed, under random
// idling on both sides, one long output hold-off and one drain pause.
// ----------------------------------------------------------------------------
module tb_top;

  // One output word as it sits on m_axis_tdata, ok in bit 0
  typedef struct packed {
    logic [6:0]                 pad;
    logic [slcf_pkg::ChanW-1:0] led1_blue;
    logic [slcf_pkg::ChanW-1:0] led1_green;
    logic [slcf_pkg::ChanW-1:0] led1_red;
    logic [slcf_pkg::ChanW-1:0] led0_blue;
    logic [slcf_pkg::ChanW-1:0] led0_green;
    logic [slcf_pkg::ChanW-1:0] led0_red;
    logic                       ok;
  } frame_t;

  // One directed stimulus row; want is used only where typed is set
  typedef struct packed {
    logic [slcf_pkg::ModeW-1:0] mode;
    logic [slcf_pkg::MsW-1:0]   ms;
    logic [slcf_pkg::PctW-1:0]  pct;
    logic                       typed;
    frame_t                     want;
  } stim_row_t;

  localparam int NumDirected    = 24;
  localparam int NumRandom      = 750;
  localparam int SinkHoldCycles = 80;
  localparam int SinkHoldAt     = 400;
  localparam int DrainLatency   = 20;

  localparam logic [slcf_pkg::ModeW-1:0] ModeBadLow = slcf_pkg::MODE_LAST + 4'd1;
  localparam logic [slcf_pkg::ModeW-1:0] ModeBadTop = 4'hF;
  localparam logic [slcf_pkg::PctW-1:0]  PctTop     = 7'h7F;
  localparam logic [slcf_pkg::PctW-1:0]  PctFull    = slcf_pkg::MaxPct;
  localparam logic [slcf_pkg::MsW-1:0]   MsTop      = '1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;

  // Bench-side state shared between the driver, the sink and the monitor
  frame_t    owed_frames[$];
  frame_t    got_frame, want_frame;
  logic      word_typed = 1'b0;
  frame_t    word_want  = '0;
  logic      idle_on    = 1'b1;
  logic      sink_hold_done = 1'b0;
  int        words_accepted = 0;
  int        frames_checked = 0;
  int        frames_rejected = 0;
  int        mismatches = 0;
  stim_row_t directed_rows [NumDirected];

  status_led_color_frame_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk = ~clk;

  // Scale one channel by a percent, truncating
  function automatic int unsigned pct_scale(input int unsigned c, input int unsigned p);
    return (c * p) / 100;
  endfunction

  // Colour frame that the core owes for one input word
  function automatic frame_t predict_frame(input logic [slcf_pkg::ModeW-1:0] mode,
                                           input logic [slcf_pkg::MsW-1:0] ms,
                                           input logic [slcf_pkg::PctW-1:0] pct);
    frame_t                   f;
    int unsigned              r, g, b, angle;
    logic [slcf_pkg::MsW-1:0] period;
    f = '0;
    r = 0;
    g = 0;
    b = 0;
    if (mode > slcf_pkg::MODE_LAST || pct > slcf_pkg::MaxPct) return f;
    f.ok = 1'b1;
    period = ms / 64'd750;
    // Blinking modes go dark in odd 750 ms periods
    if ((mode == slcf_pkg::MODE_DND || mode == slcf_pkg::MODE_AUTH ||
         mode == slcf_pkg::MODE_CONNECTING || mode == slcf_pkg::MODE_UNKNOWN) &&
        period[0]) return f;
    case (mode)
      slcf_pkg::MODE_AVAILABLE: g = 140;
      slcf_pkg::MODE_BUSY, slcf_pkg::MODE_AUTH: begin
        r = 255;
        g = 255;
      end
      slcf_pkg::MODE_DND: r = 180;
      slcf_pkg::MODE_CFG_ERR: begin
        r = 180;
        b = 180;
      end
      slcf_pkg::MODE_PLAY: begin
        angle = 32'((ms / 64'd15) % 64'd360);
        if (angle < 120) begin
          r = (120 - angle) * 255 / 120;
          g = angle * 255 / 120;
        end else if (angle < 240) begin
          g = (240 - angle) * 255 / 120;
          b = (angle - 120) * 255 / 120;
        end else begin
          r = (angle - 240) * 255 / 120;
          b = (360 - angle) * 255 / 120;
        end
        r = pct_scale(r, 30);
        g = pct_scale(g, 30);
        b = pct_scale(b, 30);
      end
      default: b = 140;
    endcase
    f.led0_red   = 8'(pct_scale(r, 32'(pct)));
    f.led0_green = 8'(pct_scale(g, 32'(pct)));
    f.led0_blue  = 8'(pct_scale(b, 32'(pct)));
    if (mode != slcf_pkg::MODE_BUSY) begin
      f.led1_red   = f.led0_red;
      f.led1_green = f.led0_green;
      f.led1_blue  = f.led0_blue;
    end
    return f;
  endfunction

  // Frame literal for the directed table
  function automatic frame_t lit_frame(input int ok,
                                       input int unsigned r0, g0, b0, r1, g1, b1);
    frame_t f;
    f = '0;
    f.ok = (ok != 0);
    f.led0_red = 8'(r0);
    f.led0_green = 8'(g0);
    f.led0_blue = 8'(b0);
    f.led1_red = 8'(r1);
    f.led1_green = 8'(g1);
    f.led1_blue = 8'(b1);
    return f;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("mismatch %0d at %0t ns: %s got %0h want %0h", mismatches, $time, what,
             got, want);
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Offer one word, with random gaps ahead of it while idling is on, and hold until taken
  task automatic send_word(input logic [slcf_pkg::ModeW-1:0] mode,
                           input logic [slcf_pkg::MsW-1:0] ms,
                           input logic [slcf_pkg::PctW-1:0] pct, input logic typed,
                           input frame_t want);
    @(negedge clk);
    if (idle_on) begin
      while ($urandom_range(99) < 18) begin
        s_axis_tvalid = 1'b0;
        @(negedge clk);
      end
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {5'b0, pct, ms, mode};
    word_typed    = typed;
    word_want     = want;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Hold until every owed frame has come back
  task automatic drain_frames;
    while (owed_frames.size() != 0) @(posedge clk);
  endtask

  // Monitor: compare output words first, then log the word taken at the input
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_frame = frame_t'(m_axis_tdata);
        if (owed_frames.size() == 0) begin
          report_mismatch("output word with no frame owed", 64'(m_axis_tdata), 64'd0);
        end else begin
          want_frame = owed_frames.pop_front();
          check_field("ok", 64'(got_frame.ok), 64'(want_frame.ok));
          check_field("led0_red", 64'(got_frame.led0_red), 64'(want_frame.led0_red));
          check_field("led0_green", 64'(got_frame.led0_green),
                      64'(want_frame.led0_green));
          check_field("led0_blue", 64'(got_frame.led0_blue), 64'(want_frame.led0_blue));
          check_field("led1_red", 64'(got_frame.led1_red), 64'(want_frame.led1_red));
          check_field("led1_green", 64'(got_frame.led1_green),
                      64'(want_frame.led1_green));
          check_field("led1_blue", 64'(got_frame.led1_blue), 64'(want_frame.led1_blue));
          check_field("zero fill", 64'(got_frame.pad), 64'(want_frame.pad));
          frames_checked++;
          if (!want_frame.ok) frames_rejected++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (word_typed)
          owed_frames.push_back(word_want);
        else
          owed_frames.push_back(predict_frame(s_axis_tdata[3:0], s_axis_tdata[67:4],
                                              s_axis_tdata[74:68]));
        words_accepted++;
      end
    end
  end

  // Sink: random back-pressure while idling is on, plus one long hold-off to fill the pipeline
  initial begin
    wait (!rst);
    forever begin
      @(negedge clk);
      if (!sink_hold_done && words_accepted >= SinkHoldAt) begin
        sink_hold_done = 1'b1;
        m_axis_tready = 1'b0;
        repeat (SinkHoldCycles) @(negedge clk);
      end
      m_axis_tready = idle_on ? ($urandom_range(99) >= 18) : 1'b1;
    end
  end

  // Watchdog
  initial begin
    #400000;
    $display("FAIL status_led_color_frame_core");
    $finish;
  end

  // Stimulus
  initial begin
    logic [slcf_pkg::ModeW-1:0] mode;
    logic [slcf_pkg::MsW-1:0]   ms;
    logic [slcf_pkg::PctW-1:0]  pct;
    int                         pick;

    directed_rows = '{
      // after reset: available at full brightness
      '{slcf_pkg::MODE_AVAILABLE, 64'd0, PctFull, 1'b1,
        lit_frame(1, 0, 140, 0, 0, 140, 0)},
      // busy lights LED 0 only
      '{slcf_pkg::MODE_BUSY, 64'd0, PctFull, 1'b1, lit_frame(1, 255, 255, 0, 0, 0, 0)},
      '{slcf_pkg::MODE_DND, 64'd0, PctFull, 1'b1, lit_frame(1, 180, 0, 0, 180, 0, 0)},
      // blink off phase in its first and last millisecond
      '{slcf_pkg::MODE_DND, 64'd750, PctFull, 1'b1, lit_frame(1, 0, 0, 0, 0, 0, 0)},
      '{slcf_pkg::MODE_AUTH, 64'd1499, PctFull, 1'b1, lit_frame(1, 0, 0, 0, 0, 0, 0)},
      '{slcf_pkg::MODE_AUTH, 64'd1500, PctFull, 1'b1,
        lit_frame(1, 255, 255, 0, 255, 255, 0)},
      // config error does not blink
      '{slcf_pkg::MODE_CFG_ERR, 64'd750, PctFull, 1'b1,
        lit_frame(1, 180, 0, 180, 180, 0, 180)},
      // hue wheel around each sector edge
      '{slcf_pkg::MODE_PLAY, 64'd0, PctFull, 1'b0, '0},
      '{slcf_pkg::MODE_PLAY, 64'd1799, PctFull, 1'b0, '0},
      '{slcf_pkg::MODE_PLAY, 64'd1800, PctFull, 1'b0, '0},
      '{slcf_pkg::MODE_PLAY, 64'd3600, PctFull, 1'b0, '0},
      '{slcf_pkg::MODE_PLAY, 64'd5399, 7'd57, 1'b0, '0},
      '{slcf_pkg::MODE_CONNECTING, 64'd749, PctFull, 1'b1,
        lit_frame(1, 0, 0, 140, 0, 0, 140)},
      '{slcf_pkg::MODE_UNKNOWN, 64'd2250, PctFull, 1'b1,
        lit_frame(1, 0, 0, 0, 0, 0, 0)},
      '{slcf_pkg::MODE_LAST, MsTop, PctFull, 1'b0, '0},
      // invalid mode codes
      '{ModeBadLow, 64'd0, 7'd50, 1'b1, lit_frame(0, 0, 0, 0, 0, 0, 0)},
      '{ModeBadTop, MsTop, PctTop, 1'b1, lit_frame(0, 0, 0, 0, 0, 0, 0)},
      // brightness too high
      '{slcf_pkg::MODE_AVAILABLE, 64'd0, PctFull + 7'd1, 1'b1,
        lit_frame(0, 0, 0, 0, 0, 0, 0)},
      '{slcf_pkg::MODE_BUSY, 64'd0, PctTop, 1'b1, lit_frame(0, 0, 0, 0, 0, 0, 0)},
      // zero brightness still reports ok
      '{slcf_pkg::MODE_AVAILABLE, 64'd0, 7'd0, 1'b1, lit_frame(1, 0, 0, 0, 0, 0, 0)},
      '{slcf_pkg::MODE_BUSY, MsTop, 7'd1, 1'b0, '0},
      '{slcf_pkg::MODE_PLAY, MsTop, PctFull, 1'b0, '0},
      '{slcf_pkg::MODE_CONNECTING, MsTop, 7'd33, 1'b0, '0},
      '{slcf_pkg::MODE_CFG_ERR, 64'd12345, 7'd99, 1'b0, '0}
    };

    // Hold reset, then release it at a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      send_word(directed_rows[i].mode, directed_rows[i].ms, directed_rows[i].pct,
                directed_rows[i].typed, directed_rows[i].want);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    drain_frames();

    for (int n = 0; n < NumRandom; n++) begin
      // long stretch with no idling on either side
      idle_on = !(n >= 150 && n < 300);
      if (n == 500) begin
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        drain_frames();
      end

      pick = $urandom_range(99);
      mode = (pick < 88) ? 4'($urandom_range(slcf_pkg::MODE_LAST))
                         : 4'($urandom_range(ModeBadTop, ModeBadLow));
      pick = $urandom_range(99);
      if (pick < 85)      pct = 7'($urandom_range(PctFull));
      else if (pick < 92) pct = pick[0] ? PctFull : 7'd0;
      else                pct = 7'($urandom_range(PctTop, PctFull + 7'd1));
      case ($urandom_range(3))
        0: ms = 64'($urandom_range(108000));
        1: ms = {$urandom, $urandom};
        2: ms = 64'($urandom_range(1000)) * 64'd750 - 64'($urandom_range(1));
        default: ms = MsTop - 64'($urandom_range(5000));
      endcase
      send_word(mode, ms, pct, 1'b0, '0);
    end
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    drain_frames();
    repeat (DrainLatency) @(posedge clk);

    $display("Ran %0d words (%0d directed): every mode code, brightness 0..127,",
             words_accepted, NumDirected);
    $display("elapsed time over the full range; %0d frames compared, %0d rejected.",
             frames_checked, frames_rejected);
    if (mismatches == 0 && owed_frames.size() == 0) begin
      $display("PASS status_led_color_frame_core");
    end else begin
      if (owed_frames.size() != 0)
        $display("%0d frames never arrived", owed_frames.size());
      $display("FAIL status_led_color_frame_core");
    end
    $finish;
  end

endmodule
